[design/dgte_pkg.sv]
// Shared constants and types for the depth grid triangle emitter.
package dgte_pkg;

	// Field widths of the configuration, item and result ports.
	localparam int DEPTH_W    = 16;
	localparam int TOL_W      = 16;
	localparam int FW_W       = 13;
	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register values after reset.
	localparam logic [FW_W-1:0]  FW_RESET  = 13'd640;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd3277;

	// Default sizes handed down from the top level.
	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int MAX_HEIGHT_DEF  = 4096;
	localparam int QUEUE_DEPTH_DEF = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH = 1'b0,
		CFG_TOLERANCE   = 1'b1
	} cfg_reg_t;

endpackage

[design/dgte_front.sv]
// Front part: configuration, raster counters, line memory and triangle tests.
module dgte_front #(
	parameter int MAX_WIDTH   = dgte_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = dgte_pkg::MAX_HEIGHT_DEF,
	parameter int QUEUE_DEPTH = dgte_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dgte_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dgte_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	input  logic [dgte_pkg::DEPTH_W-1:0]        depth,
	input  logic                                frame_start,
	output logic                                full,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
	output logic                                q_push,
	output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] q_rec
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int EW   = (WW > dgte_pkg::FW_W) ? WW : dgte_pkg::FW_W;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int ZW   = CNTW + 1;
	localparam int DW   = dgte_pkg::DEPTH_W;
	localparam int PW   = dgte_pkg::TOL_W + dgte_pkg::DEPTH_W;

	// Absolute difference of two samples.
	function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW-1:0] r;
		r = (a > b) ? (a - b) : (b - a);
		return r;
	endfunction

	logic [dgte_pkg::FW_W-1:0]  frame_width_q;
	logic [dgte_pkg::TOL_W-1:0] tolerance_q;
	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic [DW-1:0]              left_q;
	logic [DW-1:0]              line_mem [MAX_WIDTH];

	logic [EW-1:0] fw_ext;
	logic [EW-1:0] eff_width;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [RW-1:0] row_q_inc;
	logic [RW-1:0] r0_inc;
	logic [EW-1:0] c1_ext;
	logic          last_col;
	logic [CW-1:0] right_addr;
	logic          acc;

	logic          v_s1;
	logic [DW-1:0] d_s1;
	logic [DW-1:0] left_s1;
	logic [DW-1:0] top_s1;
	logic [DW-1:0] right_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          ul_ok_s1;
	logic          lr_ok_s1;

	logic          v_s2;
	logic [PW-1:0] prod_d_s2;
	logic [PW-1:0] prod_t_s2;
	logic [DW-1:0] dl_s2;
	logic [DW-1:0] dt_s2;
	logic [DW-1:0] dr_s2;
	logic [CW-1:0] col_s2;
	logic [RW-1:0] row_s2;
	logic          ul_ok_s2;
	logic          lr_ok_s2;
	logic          ul_s2;
	logic          lr_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= dgte_pkg::FW_RESET;
			tolerance_q   <= dgte_pkg::TOL_RESET;
		end else if (cfg_we) begin
			unique case (dgte_pkg::cfg_reg_t'(cfg_index))
				dgte_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_data[dgte_pkg::FW_W-1:0];
				dgte_pkg::CFG_TOLERANCE:   tolerance_q   <= cfg_data[dgte_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective width is the register clamped to the range the line memory allows.
	always_comb begin
		fw_ext = EW'(frame_width_q);
		if (fw_ext < EW'(2)) begin
			eff_width = EW'(2);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = fw_ext;
		end
	end

	// Position of the arriving item.
	always_comb begin
		row_q_inc = (row_q == RW'(MAX_HEIGHT - 1)) ? row_q : row_q + 1'b1;
		if (frame_start) begin
			c0 = '0;
			r0 = '0;
		end else if (EW'(col_q) >= eff_width) begin
			c0 = '0;
			r0 = row_q_inc;
		end else begin
			c0 = col_q;
			r0 = row_q;
		end
		r0_inc     = (r0 == RW'(MAX_HEIGHT - 1)) ? r0 : r0 + 1'b1;
		c1_ext     = EW'(c0) + EW'(1);
		last_col   = c1_ext >= eff_width;
		right_addr = last_col ? c0 : CW'(c1_ext);
	end

	assign full = (ZW'(q_count) + ZW'(v_s1) + ZW'(v_s2)) >= ZW'(QUEUE_DEPTH);
	assign acc  = push && !full;

	// Raster counters and the previous sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (acc) begin
			left_q <= depth;
			if (last_col) begin
				col_q <= '0;
				row_q <= r0_inc;
			end else begin
				col_q <= CW'(c1_ext);
				row_q <= r0;
			end
		end
	end

	// Line memory: the item overwrites its column while the two neighbors above are read.
	always_ff @(posedge clk) begin
		if (acc) begin
			line_mem[c0] <= depth;
			top_s1       <= line_mem[c0];
			right_s1     <= line_mem[right_addr];
		end
	end

	// Stage 1 and stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			d_s1     <= depth;
			left_s1  <= left_q;
			col_s1   <= c0;
			row_s1   <= r0;
			ul_ok_s1 <= (r0 != '0) && (c0 != '0);
			lr_ok_s1 <= (r0 != '0) && !last_col;
		end
	end

	// Stage 2: tolerance products and sample differences.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_d_s2 <= PW'(tolerance_q) * PW'(d_s1);
			prod_t_s2 <= PW'(tolerance_q) * PW'(top_s1);
			dl_s2     <= abs_diff(left_s1, d_s1);
			dt_s2     <= abs_diff(top_s1, d_s1);
			dr_s2     <= abs_diff(right_s1, top_s1);
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			ul_ok_s2  <= ul_ok_s1;
			lr_ok_s2  <= lr_ok_s1;
		end
	end

	// A zero centre gives a zero product, so the strict compare already rejects it.
	always_comb begin
		ul_s2 = ul_ok_s2 && ({dl_s2, 16'h0000} < prod_d_s2) && ({dt_s2, 16'h0000} < prod_d_s2);
		lr_s2 = lr_ok_s2 && ({dr_s2, 16'h0000} < prod_t_s2) && ({dt_s2, 16'h0000} < prod_t_s2);
	end

	assign q_push = v_s2 && (ul_s2 || lr_s2);
	assign q_rec  = {ul_s2, lr_s2, row_s2, col_s2};

endmodule

[design/dgte_queue.sv]
// Small queue of classified items between the front and back parts.
module dgte_queue #(
	parameter int MAX_WIDTH  = dgte_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dgte_pkg::MAX_HEIGHT_DEF,
	parameter int DEPTH      = dgte_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            q_push,
	input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] q_din,
	input  logic                                            q_pop,
	output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] q_dout,
	output logic                                            q_empty,
	output logic [$clog2(DEPTH+1)-1:0]                      q_count
);

	localparam int W    = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2;
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    entry_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!q_push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (q_push) begin
			entry_q[wr_ptr_q] <= q_din;
		end
	end

	assign q_dout  = entry_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_count = count_q;

endmodule

[design/dgte_back.sv]
// Back part: expands each queued item into its triangles, one per cycle while pop takes them.
module dgte_back #(
	parameter int MAX_WIDTH  = dgte_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dgte_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            q_empty,
	input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] q_dout,
	output logic                                            q_pop,
	input  logic                                            pop,
	output logic                                            empty,
	output logic [dgte_pkg::COORD_W-1:0]                    centre_col,
	output logic [dgte_pkg::COORD_W-1:0]                    centre_row,
	output logic [dgte_pkg::COORD_W-1:0]                    vertical_col,
	output logic [dgte_pkg::COORD_W-1:0]                    vertical_row,
	output logic [dgte_pkg::COORD_W-1:0]                    horizontal_col,
	output logic [dgte_pkg::COORD_W-1:0]                    horizontal_row,
	output logic                                            last_of_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = dgte_pkg::COORD_W;

	logic          head_ul;
	logic          head_lr;
	logic [RW-1:0] head_row;
	logic [CW-1:0] head_col;
	logic          out_valid_q;
	logic          lr_pending_q;
	logic          load;
	logic          take;
	logic          emit_ul;

	assign {head_ul, head_lr, head_row, head_col} = q_dout;

	// The output register refills when it is empty or being taken.
	assign load    = !out_valid_q || pop;
	assign take    = load && !q_empty;
	assign emit_ul = head_ul && !lr_pending_q;
	assign q_pop   = take && (!emit_ul || !head_lr);
	assign empty   = !out_valid_q;

	// Output valid and the pending second triangle of the head item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			lr_pending_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				lr_pending_q <= emit_ul && head_lr;
			end
		end
	end

	// Result payload: upper-left triangle first, then lower-right of the pixel above.
	always_ff @(posedge clk) begin
		if (take) begin
			centre_col   <= XW'(head_col);
			vertical_col <= XW'(head_col);
			if (emit_ul) begin
				centre_row     <= XW'(head_row);
				vertical_row   <= XW'(head_row - 1'b1);
				horizontal_col <= XW'(head_col - 1'b1);
				horizontal_row <= XW'(head_row);
				last_of_item   <= !head_lr;
			end else begin
				centre_row     <= XW'(head_row - 1'b1);
				vertical_row   <= XW'(head_row);
				horizontal_col <= XW'(head_col + 1'b1);
				horizontal_row <= XW'(head_row - 1'b1);
				last_of_item   <= 1'b1;
			end
		end
	end

endmodule

[design/depth_grid_triangle_emitter_top.sv]
// Top level of the depth grid triangle emitter.
// Depth samples enter in raster order through push/full and produce up to two triangles
// each, read out through empty/pop; an item with no triangle never enters the queue. The
// result register hands out one triangle a cycle while the queue holds some and pop
// takes them. The front part accepts one item every cycle as long as its queue has room:
// full rises once the queue entries plus the two items in flight reach the queue depth.
// An accepted item passes the stage 1 and stage 2 registers, the queue and the result
// register on its way out. The line memory needs no clearing after reset.
module depth_grid_triangle_emitter_top #(
	parameter int MAX_WIDTH   = dgte_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = dgte_pkg::MAX_HEIGHT_DEF,
	parameter int QUEUE_DEPTH = dgte_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dgte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dgte_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [dgte_pkg::DEPTH_W-1:0]    depth,
	input  logic                            frame_start,
	output logic                            empty,
	input  logic                            pop,
	output logic [dgte_pkg::COORD_W-1:0]    centre_col,
	output logic [dgte_pkg::COORD_W-1:0]    centre_row,
	output logic [dgte_pkg::COORD_W-1:0]    vertical_col,
	output logic [dgte_pkg::COORD_W-1:0]    vertical_row,
	output logic [dgte_pkg::COORD_W-1:0]    horizontal_col,
	output logic [dgte_pkg::COORD_W-1:0]    horizontal_row,
	output logic                            last_of_item
);

	localparam int REC_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2;
	localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);

	logic             q_push;
	logic             q_pop;
	logic             q_empty;
	logic [REC_W-1:0] q_din;
	logic [REC_W-1:0] q_dout;
	logic [CNTW-1:0]  q_count;

	// Front part: counters, line memory and triangle tests.
	dgte_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.depth      (depth),
		.frame_start(frame_start),
		.full       (full),
		.q_count    (q_count),
		.q_push     (q_push),
		.q_rec      (q_din)
	);

	// Queue of items that carry at least one triangle.
	dgte_queue #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.DEPTH     (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_din  (q_din),
		.q_pop  (q_pop),
		.q_dout (q_dout),
		.q_empty(q_empty),
		.q_count(q_count)
	);

	// Back part: one triangle per cycle onto the result ports while the reader pops.
	dgte_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_dout        (q_dout),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.centre_col    (centre_col),
		.centre_row    (centre_row),
		.vertical_col  (vertical_col),
		.vertical_row  (vertical_row),
		.horizontal_col(horizontal_col),
		.horizontal_row(horizontal_row),
		.last_of_item  (last_of_item)
	);

`ifndef NO_ASSERTIONS
	// The credit check in the front part must keep the queue from overflowing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |-> (q_count < CNTW'(QUEUE_DEPTH)))
		else $error("triangle queue overflow");

	// The back part never takes from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty triangle queue");

	// A shown triangle that is not the last of its item leaves its item at the queue head.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_of_item) |-> !q_empty)
		else $error("second triangle of an item lost");
`endif

endmodule

[dv/tb_depth_grid_triangle_emitter_top.sv]
// Self-checking testbench for the depth grid triangle emitter top level.
`timescale 1ns / 100ps

module tb_depth_grid_triangle_emitter_top;

	localparam int LAST_ROW = dgte_pkg::MAX_HEIGHT_DEF - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int XW = dgte_pkg::COORD_W;
	localparam int DW = dgte_pkg::DEPTH_W;

	typedef struct packed {
		logic [XW-1:0] centre_col;
		logic [XW-1:0] centre_row;
		logic [XW-1:0] vertical_col;
		logic [XW-1:0] vertical_row;
		logic [XW-1:0] horizontal_col;
		logic [XW-1:0] horizontal_row;
		logic          last_of_item;
	} triangle_t;

	typedef struct packed {
		logic [DW-1:0] depth;
		logic          frame_start;
	} sample_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [dgte_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dgte_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            push;
	logic                            full;
	logic [DW-1:0]                   depth;
	logic                            frame_start;
	logic                            empty;
	logic                            pop;
	logic [XW-1:0]                   centre_col;
	logic [XW-1:0]                   centre_row;
	logic [XW-1:0]                   vertical_col;
	logic [XW-1:0]                   vertical_row;
	logic [XW-1:0]                   horizontal_col;
	logic [XW-1:0]                   horizontal_row;
	logic                            last_of_item;

	// Samples waiting to be pushed and triangles waiting to come out.
	sample_t   sample_queue[$];
	triangle_t triangle_queue[$];
	int        mismatch_count = 0;

	// Shadow of the block's registers and raster state.
	logic [dgte_pkg::FW_W-1:0]  width_reg = dgte_pkg::FW_RESET;
	logic [dgte_pkg::TOL_W-1:0] tol_reg   = dgte_pkg::TOL_RESET;
	logic [DW-1:0]              row_above[dgte_pkg::MAX_WIDTH_DEF];
	logic [DW-1:0]              left_depth = '0;
	int                         col_pos = 0;
	int                         row_pos = 0;

	// Sender burst and receiver stall state.
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_age = 0;
	logic [15:0] pop_pattern = 16'hFFFF;

	depth_grid_triangle_emitter_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.depth          (depth),
		.frame_start    (frame_start),
		.empty          (empty),
		.pop            (pop),
		.centre_col     (centre_col),
		.centre_row     (centre_row),
		.vertical_col   (vertical_col),
		.vertical_row   (vertical_row),
		.horizontal_col (horizontal_col),
		.horizontal_row (horizontal_row),
		.last_of_item   (last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Row width as the block uses it: the register clamped to the legal span.
	function automatic int clamped_width(input logic [dgte_pkg::FW_W-1:0] fw);
		if (fw < 2) begin
			return 2;
		end
		if (fw > dgte_pkg::MAX_WIDTH_DEF) begin
			return dgte_pkg::MAX_WIDTH_DEF;
		end
		return int'(fw);
	endfunction

	// Relative depth test: |nb - centre| * 2^16 < tolerance * centre, centre nonzero.
	function automatic bit depth_close(input logic [DW-1:0] centre,
			input logic [DW-1:0] nb);
		longint diff;
		if (centre == 0) begin
			return 1'b0;
		end
		diff = (nb > centre) ? longint'(nb) - longint'(centre)
				: longint'(centre) - longint'(nb);
		return (diff << 16) < longint'(tol_reg) * longint'(centre);
	endfunction

	// Advance the raster position for one sample and queue the triangles it emits.
	task automatic predict_triangles(input logic [DW-1:0] d, input logic fs);
		int            w;
		int            c;
		int            r;
		int            n;
		logic [DW-1:0] up;
		logic [DW-1:0] rt;
		triangle_t     found[2];
		w = clamped_width(width_reg);
		n = 0;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end else if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < LAST_ROW) begin
				row_pos++;
			end
		end
		c = col_pos;
		r = row_pos;
		up = row_above[c];
		rt = (c + 1 < w) ? row_above[c + 1] : '0;

		// Upper-left triangle of the arriving pixel.
		if (r > 0 && c > 0 && d != 0 && depth_close(d, left_depth) && depth_close(d, up)) begin
			found[n].centre_col = XW'(c);
			found[n].centre_row = XW'(r);
			found[n].vertical_col = XW'(c);
			found[n].vertical_row = XW'(r - 1);
			found[n].horizontal_col = XW'(c - 1);
			found[n].horizontal_row = XW'(r);
			found[n].last_of_item = 1'b0;
			n++;
		end
		// Lower-right triangle of the pixel above.
		if (r > 0 && c + 1 < w && up != 0 && depth_close(up, rt) && depth_close(up, d)) begin
			found[n].centre_col = XW'(c);
			found[n].centre_row = XW'(r - 1);
			found[n].vertical_col = XW'(c);
			found[n].vertical_row = XW'(r);
			found[n].horizontal_col = XW'(c + 1);
			found[n].horizontal_row = XW'(r - 1);
			found[n].last_of_item = 1'b0;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			found[k].last_of_item = (k == n - 1);
			triangle_queue = {triangle_queue, found[k]};
		end

		row_above[c] = d;
		left_depth = d;
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r < LAST_ROW) begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin : sample_feed
		logic go;
		if (arst_n) begin
			if (push && !full) begin
				predict_triangles(sample_queue[0].depth, sample_queue[0].frame_start);
				void'(sample_queue.pop_front());
				if (burst_left > 0) begin
					burst_left--;
				end
			end
			if (burst_left == 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			go = (burst_left > 0) && (sample_queue.size() > 0);
			push <= go;
			if (go) begin
				depth <= sample_queue[0].depth;
				frame_start <= sample_queue[0].frame_start;
			end
		end
	end

	// Receiver: pops on a rotating pattern that is redrawn now and then.
	always @(posedge clk) begin : triangle_check
		triangle_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (triangle_queue.size() == 0) begin
					$error("triangle at (%0d,%0d) arrived with none expected",
						centre_col, centre_row);
					mismatch_count++;
				end else begin
					want = triangle_queue.pop_front();
					if (centre_col !== want.centre_col) begin
						$error("centre_col: expected %0d, got %0d", want.centre_col, centre_col);
						mismatch_count++;
					end
					if (centre_row !== want.centre_row) begin
						$error("centre_row: expected %0d, got %0d", want.centre_row, centre_row);
						mismatch_count++;
					end
					if (vertical_col !== want.vertical_col) begin
						$error("vertical_col: expected %0d, got %0d",
							want.vertical_col, vertical_col);
						mismatch_count++;
					end
					if (vertical_row !== want.vertical_row) begin
						$error("vertical_row: expected %0d, got %0d",
							want.vertical_row, vertical_row);
						mismatch_count++;
					end
					if (horizontal_col !== want.horizontal_col) begin
						$error("horizontal_col: expected %0d, got %0d",
							want.horizontal_col, horizontal_col);
						mismatch_count++;
					end
					if (horizontal_row !== want.horizontal_row) begin
						$error("horizontal_row: expected %0d, got %0d",
							want.horizontal_row, horizontal_row);
						mismatch_count++;
					end
					if (last_of_item !== want.last_of_item) begin
						$error("last_of_item: expected %0d, got %0d",
							want.last_of_item, last_of_item);
						mismatch_count++;
					end
				end
			end
			stall_age++;
			if (stall_age == 97) begin
				stall_age = 0;
				// The forced bits, set at every fifth position, bound the length of any stall.
				pop_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
						: (16'($urandom) | 16'h8421);
			end
			pop <= pop_pattern[0];
			pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
		end
	end

	// Wait until every item is in and every triangle out, then let the pipeline empty.
	task automatic settle();
		while (sample_queue.size() != 0 || push || triangle_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dgte_pkg::cfg_reg_t idx,
			input logic [dgte_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == dgte_pkg::CFG_FRAME_WIDTH) begin
			width_reg = val[dgte_pkg::FW_W-1:0];
		end else begin
			tol_reg = val;
		end
	endtask

	task automatic set_regs(input logic [dgte_pkg::CFG_DATA_W-1:0] fw_val,
			input logic [dgte_pkg::CFG_DATA_W-1:0] tol_val);
		settle();
		write_reg(dgte_pkg::CFG_FRAME_WIDTH, fw_val);
		write_reg(dgte_pkg::CFG_TOLERANCE, tol_val);
	endtask

	task automatic add_item(input int d, input bit fs);
		sample_t s;
		s.depth = DW'(d);
		s.frame_start = fs;
		sample_queue = {sample_queue, s};
	endtask

	// Typical surface depth, with the extremes of the range drawn often.
	function automatic int pick_base();
		case ($urandom_range(0, 7))
			0: return $urandom_range(1, 64);
			1: return $urandom_range(65000, 65535);
			default: return $urandom_range(64, 65535);
		endcase
	endfunction

	// A smooth surface around a drifting base: mostly samples within the tolerance
	// band, some holes, some wild values and, optionally, stray frame starts.
	task automatic add_surface(input int count, input bit open_frame, input int fs_pct);
		int base;
		int lim;
		int v;
		int pick;
		bit fs;
		base = pick_base();
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 49) == 0) begin
				base = pick_base();
			end
			lim = int'((longint'(base) * longint'(tol_reg)) >> 16);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				v = 0;
			end else if (pick < 12) begin
				v = $urandom_range(0, 65535);
			end else begin
				v = base + int'($urandom_range(0, 2 * lim + 2)) - (lim + 1);
				if (v < 1) begin
					v = 1;
				end
				if (v > 65535) begin
					v = 65535;
				end
			end
			fs = (k == 0 && open_frame) || (int'($urandom_range(0, 99)) < fs_pct);
			add_item(v, fs);
		end
	endtask

	// Reset, directed cases, runs at both width extremes, then random phases.
	initial begin : stimulus
		int                              placed;
		int                              prev_w;
		int                              phase_items;
		logic [dgte_pkg::CFG_DATA_W-1:0] fw_val;
		logic [dgte_pkg::CFG_DATA_W-1:0] tol_val;
		bit                              open_frame;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dgte_pkg::CFG_FRAME_WIDTH;
		cfg_data = '0;
		push = 1'b0;
		depth = '0;
		frame_start = 1'b0;
		pop = 1'b0;
		foreach (row_above[i]) begin
			row_above[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Three-wide frame: first row, first column, right edge, holes, both triangles
		// from one sample, and samples at the top of the depth range.
		set_regs(16'd3, 16'd3277);
		add_item(100, 1'b1);
		add_item(100, 1'b0);
		add_item(100, 1'b0);
		add_item(100, 1'b0);
		add_item(104, 1'b0);
		add_item(0, 1'b0);
		add_item(65535, 1'b0);
		add_item(65535, 1'b0);
		add_item(65535, 1'b0);
		add_item(65535, 1'b0);
		add_item(65534, 1'b0);
		add_item(65535, 1'b0);

		// Width shrinks below the current column: the next sample opens a new row.
		set_regs(16'd5, 16'd65535);
		add_item(7, 1'b1);
		for (int k = 0; k < 6; k++) begin
			add_item(7 + k, 1'b0);
		end
		set_regs(16'hE002, 16'd65535);
		add_item(9, 1'b0);
		add_item(8, 1'b0);

		// Zero tolerance never passes; width below two acts as two.
		set_regs(16'd1, 16'd0);
		add_item(500, 1'b1);
		add_item(500, 1'b0);
		add_item(500, 1'b0);
		add_item(500, 1'b0);

		// Largest register value, clamped to the maximum width; a partial first row.
		set_regs(16'hFFFF, 16'd3277);
		add_surface(64, 1'b1, 0);

		// Narrowest rows over many rows.
		set_regs(16'h0000, 16'd6553);
		add_surface(200, 1'b1, 0);

		// Random phases. A frame start opens the phase whenever the row grows wider.
		prev_w = 2;
		placed = 0;
		while (placed < 560) begin
			case ($urandom_range(0, 9))
				0: fw_val = 16'($urandom_range(0, 1));
				1: fw_val = 16'($urandom_range(13, 40));
				2: fw_val = 16'(dgte_pkg::MAX_WIDTH_DEF);
				default: fw_val = 16'($urandom_range(2, 12));
			endcase
			fw_val[15:13] = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0: tol_val = 16'd0;
				1: tol_val = 16'hFFFF;
				2: tol_val = 16'($urandom_range(0, 65535));
				default: tol_val = 16'($urandom_range(1000, 12000));
			endcase
			open_frame = (clamped_width(fw_val[dgte_pkg::FW_W-1:0]) > prev_w)
					|| $urandom_range(0, 1);
			prev_w = clamped_width(fw_val[dgte_pkg::FW_W-1:0]);
			// Keep the widest rows to a single partial row.
			phase_items = (prev_w == dgte_pkg::MAX_WIDTH_DEF) ? 40 : $urandom_range(60, 120);
			if (prev_w == dgte_pkg::MAX_WIDTH_DEF) begin
				open_frame = 1'b1;
			end
			set_regs(fw_val, tol_val);
			add_surface(phase_items, open_frame, (prev_w == dgte_pkg::MAX_WIDTH_DEF) ? 0 : 3);
			placed += phase_items;
		end

		settle();
		if (mismatch_count == 0 && triangle_queue.size() == 0) begin
			$display("depth_grid_triangle_emitter_top verification clean");
		end else begin
			$display("depth_grid_triangle_emitter_top verification failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("depth_grid_triangle_emitter_top verification failed");
		$finish;
	end

endmodule

[files.f]
design/dgte_pkg.sv
design/dgte_front.sv
design/dgte_queue.sv
design/dgte_back.sv
design/depth_grid_triangle_emitter_top.sv
dv/tb_depth_grid_triangle_emitter_top.sv
